// File: src/power_of_two_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// Power-of-two page allocator: assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef POWER_OF_TWO_PAGE_ALLOCATOR_MACROS_SVH
`define POWER_OF_TWO_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge while reset is released.
`define P2PA_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define P2PA_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define P2PA_ASSERT(name, clk, rstn, prop, msg)
`define P2PA_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: src/p2pa_pkg.sv
// ----------------------------------------------------------------------------
// Power-of-two page allocator package
// Transfer types, status and register codes, and the request order function.
// ----------------------------------------------------------------------------
package p2pa_pkg;

    localparam int unsigned NUM_ORDERS_DEF     = 16;
    localparam int unsigned REGION_PAGES_DEF   = 65536;
    localparam int unsigned PAGE_W             = 36;
    localparam int unsigned REQ_W              = 16;
    localparam int unsigned REQ_ORD_W          = 5;
    localparam int unsigned REGION_PAGES_REG_W = 17;
    localparam int unsigned CFG_DATA_W         = 36;
    localparam int unsigned CFG_IDX_W          = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE_PAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES     = 1'b1;

    localparam logic ACTION_ALLOC = 1'b0;
    localparam logic ACTION_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_MEMORY   = 2'd1,
        STATUS_TOO_LARGE   = 2'd2,
        STATUS_BAD_ADDRESS = 2'd3
    } status_t;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  request_pages;
        logic [PAGE_W-1:0] page_number;
    } in_item_t;

    typedef struct packed {
        logic [PAGE_W-1:0] granted_page;
        status_t           status;
    } out_item_t;

    // Smallest k with 2^k >= req; a request of zero counts as one page.
    function automatic logic [REQ_ORD_W-1:0] order_of(input logic [REQ_W-1:0] req);
        logic [REQ_W-1:0]     r;
        logic [REQ_ORD_W-1:0] k;
        r = req - REQ_W'(1);
        k = '0;
        if (req > REQ_W'(1)) begin
            for (int n = 0; n < REQ_W; n++) begin
                if (r[n]) begin
                    k = REQ_ORD_W'(n + 1);
                end
            end
        end
        return k;
    endfunction

endpackage

// File: src/power_of_two_page_allocator.sv
// ----------------------------------------------------------------------------
// Power-of-two page allocator
// Free-list allocator over one page region with split-on-allocate, bump
// fallback and push-only free, linked through an on-chip next-link memory.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+-----------------------------
//  s_       | in        | s_valid / s_ready  | p2pa_pkg::in_item_t
//  m_       | out       | m_valid / m_ready  | p2pa_pkg::out_item_t
//  cfg_     | in        | cfg_we             | cfg_index, cfg_data
//
// A free, a bump allocation or a rejected request passes through DECODE and
// then DONE, which loads the output register once it is free; an allocation from
// a free list passes through DECODE, POP, one SPLIT per order step, then DONE.
// One split half is pushed per cycle through the single link memory write port.
// The next request is taken once the previous result is staged,
// even while that result still waits for m_ready.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "power_of_two_page_allocator_macros.svh"

module power_of_two_page_allocator #(
    parameter int unsigned NUM_ORDERS   = p2pa_pkg::NUM_ORDERS_DEF,
    parameter int unsigned REGION_PAGES = p2pa_pkg::REGION_PAGES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  p2pa_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output p2pa_pkg::out_item_t                m_data,
    input  logic                               cfg_we,
    input  logic [p2pa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [p2pa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned ORD_W  = $clog2(NUM_ORDERS);
    localparam int unsigned OFF_W  = $clog2(REGION_PAGES);
    localparam int unsigned LEN_W  = OFF_W + 1;
    localparam int unsigned WIDE_A = (LEN_W > p2pa_pkg::REGION_PAGES_REG_W) ?
                                     LEN_W : p2pa_pkg::REGION_PAGES_REG_W;
    localparam int unsigned CMP_W  = ((WIDE_A > NUM_ORDERS) ? WIDE_A : NUM_ORDERS) + 1;
    localparam int unsigned PW     = p2pa_pkg::PAGE_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_POP    = 5'b00100,
        S_SPLIT  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                                state_reg, state_next;
    logic [PW-1:0]                         base_reg;
    logic [p2pa_pkg::REGION_PAGES_REG_W-1:0] pages_reg;
    logic [OFF_W-1:0]                      heads_reg [NUM_ORDERS];
    logic [NUM_ORDERS-1:0]                 mask_reg;
    logic [LEN_W-1:0]                      bump_reg, bump_next;
    p2pa_pkg::in_item_t                    item_reg;
    logic [p2pa_pkg::REQ_ORD_W-1:0]        k_reg;
    logic [ORD_W-1:0]                      i_reg, i_next;
    logic [OFF_W-1:0]                      off_reg, off_next;
    p2pa_pkg::out_item_t                   res_reg, res_next;
    logic                                  m_valid_reg, m_valid_next;
    p2pa_pkg::out_item_t                   m_data_reg;

    logic [OFF_W:0]                        links_mem [REGION_PAGES];
    logic [OFF_W:0]                        rd_data_reg;

    logic                    s_accept;
    logic                    out_load;
    logic [CMP_W-1:0]        len_c;
    logic [ORD_W-1:0]        k_idx;
    logic                    too_large;
    logic [PW-1:0]           diff;
    logic                    outside;
    logic [NUM_ORDERS-1:0]   avail;
    logic [ORD_W-1:0]        src_idx;
    logic [CMP_W-1:0]        bump_sum;
    logic                    bump_fits;
    logic [ORD_W-1:0]        split_idx;
    logic [CMP_W-1:0]        half;
    logic [ORD_W-1:0]        head_rd_idx;
    logic [OFF_W-1:0]        head_rd;
    logic                    push_en;
    logic [ORD_W-1:0]        push_ord;
    logic [OFF_W-1:0]        push_off;
    logic                    pop_en;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign len_c = (CMP_W'(pages_reg) < CMP_W'(REGION_PAGES)) ?
                   CMP_W'(pages_reg) : CMP_W'(REGION_PAGES);

    assign k_idx     = k_reg[ORD_W-1:0];
    assign too_large = ({1'b0, k_reg} >= (p2pa_pkg::REQ_ORD_W + 1)'(NUM_ORDERS));
    assign diff      = item_reg.page_number - base_reg;
    assign outside   = (item_reg.page_number < base_reg) || (diff >= PW'(len_c));

    assign avail = mask_reg & ({NUM_ORDERS{1'b1}} << k_reg);

    // Lowest non-empty list at or above the requested order.
    always_comb begin
        src_idx = '0;
        for (int n = NUM_ORDERS - 1; n >= 0; n--) begin
            if (avail[n]) begin
                src_idx = ORD_W'(n);
            end
        end
    end

    assign bump_sum  = CMP_W'(bump_reg) + (CMP_W'(1) << k_reg);
    assign bump_fits = (bump_sum <= len_c);

    assign split_idx = i_reg - ORD_W'(1);
    assign half      = CMP_W'(off_reg) + (CMP_W'(1) << split_idx);

    // The head table has a single read port shared by decode and split.
    always_comb begin
        case (state_reg)
            S_DECODE: head_rd_idx = (item_reg.action == p2pa_pkg::ACTION_FREE) ?
                                    k_idx : src_idx;
            default:  head_rd_idx = split_idx;
        endcase
    end
    assign head_rd = heads_reg[head_rd_idx];

    always_comb begin
        state_next = state_reg;
        bump_next  = bump_reg;
        i_next     = i_reg;
        off_next   = off_reg;
        res_next   = res_reg;
        push_en    = 1'b0;
        push_ord   = head_rd_idx;
        push_off   = diff[OFF_W-1:0];
        pop_en     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                res_next.granted_page = '0;
                res_next.status       = p2pa_pkg::STATUS_OK;
                state_next            = S_DONE;
                if (too_large) begin
                    res_next.status = p2pa_pkg::STATUS_TOO_LARGE;
                end else if (item_reg.action == p2pa_pkg::ACTION_FREE) begin
                    if (outside) begin
                        res_next.status = p2pa_pkg::STATUS_BAD_ADDRESS;
                    end else begin
                        push_en = 1'b1;
                    end
                end else if (avail != '0) begin
                    // The link memory read of the popped head is issued here.
                    i_next     = src_idx;
                    off_next   = head_rd;
                    state_next = S_POP;
                end else if (bump_fits) begin
                    res_next.granted_page = base_reg + PW'(bump_reg);
                    bump_next             = bump_sum[LEN_W-1:0];
                end else begin
                    res_next.status = p2pa_pkg::STATUS_NO_MEMORY;
                end
            end
            S_POP: begin
                pop_en = 1'b1;
                res_next.granted_page = base_reg + PW'(off_reg);
                res_next.status       = p2pa_pkg::STATUS_OK;
                state_next = (32'(i_reg) > 32'(k_reg)) ? S_SPLIT : S_DONE;
            end
            S_SPLIT: begin
                // Upper half goes to the next lower list unless it leaves the table.
                push_en    = (half < CMP_W'(REGION_PAGES));
                push_ord   = split_idx;
                push_off   = half[OFF_W-1:0];
                i_next     = split_idx;
                if (split_idx == k_idx) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            base_reg    <= '0;
            pages_reg   <= '0;
            mask_reg    <= '0;
            bump_reg    <= '0;
            for (int n = 0; n < NUM_ORDERS; n++) begin
                heads_reg[n] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bump_reg    <= bump_next;
            if (cfg_we) begin
                case (cfg_index)
                    p2pa_pkg::CFG_REGION_BASE_PAGE: base_reg <= cfg_data[PW-1:0];
                    p2pa_pkg::CFG_REGION_PAGES:
                        pages_reg <= cfg_data[p2pa_pkg::REGION_PAGES_REG_W-1:0];
                    default: ;
                endcase
            end
            if (push_en) begin
                heads_reg[push_ord] <= push_off;
                mask_reg[push_ord]  <= 1'b1;
            end
            if (pop_en) begin
                if (rd_data_reg[OFF_W]) begin
                    heads_reg[i_reg] <= rd_data_reg[OFF_W-1:0];
                end else begin
                    heads_reg[i_reg] <= '0;
                    mask_reg[i_reg]  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_data;
            k_reg    <= p2pa_pkg::order_of(s_data.request_pages);
        end
        i_reg   <= i_next;
        off_reg <= off_next;
        res_reg <= res_next;
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    // Next-link memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (push_en) begin
            links_mem[push_off] <= {mask_reg[push_ord], head_rd};
        end
        if (state_reg == S_DECODE) begin
            rd_data_reg <= links_mem[head_rd];
        end
    end

    `P2PA_ASSERT(a_split_above_target, aclk, aresetn, state_reg == S_SPLIT |-> 32'(i_reg) > 32'(k_reg), "split order has fallen to the requested order")
    `P2PA_ASSERT(a_pop_nonempty, aclk, aresetn, state_reg == S_POP |-> mask_reg[i_reg], "pop from an empty free list")
    `P2PA_ASSERT(a_fail_zero_page, aclk, aresetn, m_valid_reg && m_data_reg.status != p2pa_pkg::STATUS_OK |-> m_data_reg.granted_page == '0, "failed request carries a page number")
    `P2PA_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state_reg == S_IDLE && !m_valid_reg, "sequencer or output not cleared by reset")

endmodule
